// ===== rtl/pcx_rle_scanline_decoder_macros.svh =====
// Assertion helpers for the checker file of the decoder.
`ifndef PCX_RLE_SCANLINE_DECODER_MACROS_SVH
`define PCX_RLE_SCANLINE_DECODER_MACROS_SVH

// Checked on every clock edge outside reset.
`define PCX_RLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PCX_RLE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/pcx_rle_pkg.sv =====
package pcx_rle_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_CNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPL        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;

  // Marker byte decoding
  localparam logic [7:0] MARKER_MASK = 8'hC0;
  localparam logic [5:0] COUNT_MASK  = 6'h3F;

  // Command queue depth between front and back
  localparam int unsigned CMD_DEPTH = 2;

  typedef struct packed {
    logic        rle_enable;
    logic [1:0]  pixel_bits_code;
    logic [2:0]  plane_count;
    logic [15:0] bytes_per_plane_line;
    logic [16:0] image_width;
    logic [16:0] image_height;
  } cfg_t;

  // One byte to repeat count times (a literal has count one)
  typedef struct packed {
    logic [7:0] value;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  pixel_byte;
    logic [1:0]  plane_index;
    logic [15:0] line_number;
    logic [18:0] first_column;
    logic [3:0]  valid_pixels;
    logic        line_end;
    logic        image_end;
    logic        run_end;
    logic        run_error;
  } res_t;

endpackage

// ===== rtl/pcx_rle_front.sv =====
module pcx_rle_front import pcx_rle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rle_enable_i,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cmd_t       q_data_o
);

  logic       await_q, await_d;
  logic [5:0] count_q, count_d;
  logic       take;

  assign take = push_i && !q_full_i;

  // Classify the byte: marker, run value or literal
  always_comb begin
    await_d  = await_q;
    count_d  = count_q;
    q_push_o = 1'b0;
    q_data_o = '{value: data_byte_i, count: 6'd1};
    if (take) begin
      if (await_q) begin
        await_d  = 1'b0;
        count_d  = '0;
        q_data_o = '{value: data_byte_i, count: count_q};
        q_push_o = (count_q != 6'd0);
      end else if (rle_enable_i && ((data_byte_i & MARKER_MASK) == MARKER_MASK)) begin
        await_d = 1'b1;
        count_d = data_byte_i[5:0] & COUNT_MASK;
      end else begin
        q_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q <= 1'b0;
      count_q <= '0;
    end else begin
      await_q <= await_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/pcx_rle_cmdq.sv =====
module pcx_rle_cmdq import pcx_rle_pkg::*; #(
  parameter int unsigned Depth = CMD_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/pcx_rle_back.sv =====
module pcx_rle_back import pcx_rle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_empty_i,
  input  cmd_t q_head_i,
  output logic q_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  // Run and position state
  logic        busy_q, busy_d;
  logic [5:0]  rem_q, rem_d;
  logic [7:0]  val_q, val_d;
  logic [15:0] bp_q, bp_d;
  logic [1:0]  cp_q, cp_d;
  logic [15:0] cl_q, cl_d;
  logic        halted_q, halted_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;

  // Effective configuration
  logic [15:0] bpl;
  logic [2:0]  planes;
  logic [16:0] height;
  logic [3:0]  ppb;
  logic [1:0]  col_shift;

  // Per-byte tags
  logic [18:0] col;
  logic [18:0] width_ext;
  logic [18:0] col_room;
  logic [3:0]  valid;
  logic [2:0]  cp_next;
  logic        plane_done, line_done, image_done;

  // Room left in the line
  logic [15:0] in_plane;
  logic [2:0]  later;
  logic [17:0] left;
  logic        overflow;

  // Sequencing
  logic        out_free, start, step, emit;
  logic [7:0]  emit_val;
  logic        emit_last;

  always_comb begin
    bpl = (cfg_i.bytes_per_plane_line == 16'd0) ? 16'd1 : cfg_i.bytes_per_plane_line;
    if (cfg_i.plane_count == 3'd0) begin
      planes = 3'd1;
    end else if (cfg_i.plane_count > 3'd4) begin
      planes = 3'd4;
    end else begin
      planes = cfg_i.plane_count;
    end
    if (cfg_i.image_height == 17'd0) begin
      height = 17'd1;
    end else if (cfg_i.image_height > 17'h10000) begin
      height = 17'h10000;
    end else begin
      height = cfg_i.image_height;
    end
    ppb       = 4'd8 >> cfg_i.pixel_bits_code;
    col_shift = 2'd3 - cfg_i.pixel_bits_code;
  end

  // Column, visible pixels and end-of-plane/line/image flags
  always_comb begin
    col       = 19'(bp_q) << col_shift;
    width_ext = 19'(cfg_i.image_width);
    col_room  = width_ext - col;
    if (col < width_ext) begin
      valid = (col_room > 19'(ppb)) ? ppb : col_room[3:0];
    end else begin
      valid = 4'd0;
    end
    cp_next    = 3'(cp_q) + 3'd1;
    plane_done = (17'(bp_q) + 17'd1) >= 17'(bpl);
    line_done  = plane_done && (cp_next >= planes);
    image_done = line_done && ((17'(cl_q) + 17'd1) >= height);
  end

  // Bytes left in the line, current byte included
  always_comb begin
    in_plane = (bp_q < bpl) ? (bpl - bp_q) : 16'd1;
    later    = (cp_next < planes) ? (planes - cp_next) : 3'd0;
    left     = 18'(in_plane)
             + (later[0] ? 18'(bpl) : 18'd0)
             + (later[1] ? (18'(bpl) << 1) : 18'd0);
    overflow = 18'(q_head_i.count) > left;
  end

  // Run sequencing and output register
  always_comb begin
    out_free  = !out_valid_q || pop_i;
    start     = !busy_q && !q_empty_i && !halted_q && out_free;
    step      = busy_q && out_free;
    emit      = step || (start && !overflow);
    emit_val  = busy_q ? val_q : q_head_i.value;
    emit_last = busy_q ? (rem_q == 6'd1) : (q_head_i.count == 6'd1);
    q_pop_o   = !q_empty_i && (halted_q || (!busy_q && out_free));

    busy_d      = busy_q;
    rem_d       = rem_q;
    val_d       = val_q;
    bp_d        = bp_q;
    cp_d        = cp_q;
    cl_d        = cl_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;

    if (start && overflow) begin
      res_d           = '0;
      res_d.run_end   = 1'b1;
      res_d.run_error = 1'b1;
      halted_d        = 1'b1;
      out_valid_d     = 1'b1;
    end else if (emit) begin
      res_d.pixel_byte   = emit_val;
      res_d.plane_index  = cp_q;
      res_d.line_number  = cl_q;
      res_d.first_column = col;
      res_d.valid_pixels = valid;
      res_d.line_end     = line_done;
      res_d.image_end    = image_done;
      res_d.run_end      = emit_last;
      res_d.run_error    = 1'b0;
      out_valid_d        = 1'b1;
      if (!plane_done) begin
        bp_d = bp_q + 16'd1;
      end else begin
        bp_d = '0;
        if (!line_done) begin
          cp_d = cp_q + 2'd1;
        end else begin
          cp_d = '0;
          cl_d = image_done ? 16'd0 : cl_q + 16'd1;
        end
      end
      if (start) begin
        busy_d = !emit_last;
        rem_d  = q_head_i.count - 6'd1;
        val_d  = q_head_i.value;
      end else begin
        busy_d = !emit_last;
        rem_d  = rem_q - 6'd1;
      end
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      bp_q        <= '0;
      cp_q        <= '0;
      cl_q        <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      bp_q        <= bp_d;
      cp_q        <= cp_d;
      cl_q        <= cl_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
  end

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/pcx_rle_scanline_decoder.sv =====
// A literal or run value byte passes the command queue, then the output register.
// Throughput: one result per cycle while the output register is free or popped; a run
// of n bytes gives n results; the back end writes one byte per cycle into that register.
// A 2-entry command queue lets markers and literals keep arriving while a run expands.
// Reset: rst_ni asynchronous active low; clears counters, halt flag, command queue and
// loads the register defaults. A run error halts the block until the next reset.
module pcx_rle_scanline_decoder import pcx_rle_pkg::*; #(
  parameter int unsigned CmdDepth = CMD_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Byte input
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            data_byte_i,
  // Result output
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            pixel_byte_o,
  output logic [1:0]            plane_index_o,
  output logic [15:0]           line_number_o,
  output logic [18:0]           first_column_o,
  output logic [3:0]            valid_pixels_o,
  output logic                  line_end_o,
  output logic                  image_end_o,
  output logic                  run_end_o,
  output logic                  run_error_o
);

  cfg_t cfg_q;
  cmd_t push_cmd, head_cmd;
  logic q_push, q_full, q_pop, q_empty;
  res_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_enable           <= 1'b1;
      cfg_q.pixel_bits_code      <= 2'd3;
      cfg_q.plane_count          <= 3'd1;
      cfg_q.bytes_per_plane_line <= 16'd1;
      cfg_q.image_width          <= 17'd1;
      cfg_q.image_height         <= 17'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RLE_ENABLE: cfg_q.rle_enable           <= cfg_data_i[0];
        REG_PIXEL_BITS: cfg_q.pixel_bits_code      <= cfg_data_i[1:0];
        REG_PLANE_CNT:  cfg_q.plane_count          <= cfg_data_i[2:0];
        REG_BPL:        cfg_q.bytes_per_plane_line <= cfg_data_i[15:0];
        REG_WIDTH:      cfg_q.image_width          <= cfg_data_i[16:0];
        REG_HEIGHT:     cfg_q.image_height         <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  pcx_rle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rle_enable_i (cfg_q.rle_enable),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (push_cmd)
  );

  pcx_rle_cmdq #(
    .Depth (CmdDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (head_cmd),
    .empty_o (q_empty)
  );

  pcx_rle_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_head_i  (head_cmd),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (res)
  );

  assign full           = q_full;
  assign pixel_byte_o   = res.pixel_byte;
  assign plane_index_o  = res.plane_index;
  assign line_number_o  = res.line_number;
  assign first_column_o = res.first_column;
  assign valid_pixels_o = res.valid_pixels;
  assign line_end_o     = res.line_end;
  assign image_end_o    = res.image_end;
  assign run_end_o      = res.run_end;
  assign run_error_o    = res.run_error;

endmodule

// ===== rtl/pcx_rle_checker.sv =====
`include "pcx_rle_scanline_decoder_macros.svh"

module pcx_rle_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input logic [7:0]            pixel_byte_o,
  input logic [1:0]            plane_index_o,
  input logic [15:0]           line_number_o,
  input logic [18:0]           first_column_o,
  input logic [3:0]            valid_pixels_o,
  input logic                  line_end_o,
  input logic                  image_end_o,
  input logic                  run_end_o,
  input logic                  run_error_o
);

  // A waiting result holds until it is popped
  `PCX_RLE_ASSERT(a_res_hold, !empty && !pop |=> !empty && $stable(pixel_byte_o) && $stable(first_column_o) && $stable(run_end_o), "result changed while waiting")

  // An error result carries nothing but its two flags
  `PCX_RLE_ASSERT(a_err_clean, !empty && run_error_o |-> pixel_byte_o == 8'd0 && plane_index_o == 2'd0 && line_number_o == 16'd0 && first_column_o == 19'd0 && valid_pixels_o == 4'd0 && !line_end_o && !image_end_o && run_end_o, "error result not clean")

  // The image ends only at a line end
  `PCX_RLE_ASSERT(a_img_line, !empty && image_end_o |-> line_end_o, "image end without line end")

  // Nothing follows an error once it is transferred
  `PCX_RLE_ASSERT(a_err_halt, !empty && run_error_o && pop |=> empty, "result after run error")

  // No result once reset has been seen at a clock edge
  `PCX_RLE_ASSERT_RST(a_rst_empty, !rst_ni |=> empty, "result shown during reset")

endmodule

bind pcx_rle_scanline_decoder pcx_rle_checker u_checker (.*);

// ===== dv/pcx_rle_scanline_decoder_test.sv =====
`timescale 1ns / 100ps

module pcx_rle_scanline_decoder_test;
  import pcx_rle_pkg::*;

  // Decoder state as the scoreboard tracks it
  typedef struct packed {
    logic        await_value;
    logic [5:0]  pending_count;
    logic [15:0] byte_pos;
    logic [1:0]  plane;
    logic [15:0] line;
    logic        halted;
  } dec_state_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            data_byte_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            pixel_byte_o;
  logic [1:0]            plane_index_o;
  logic [15:0]           line_number_o;
  logic [18:0]           first_column_o;
  logic [3:0]            valid_pixels_o;
  logic                  line_end_o;
  logic                  image_end_o;
  logic                  run_end_o;
  logic                  run_error_o;

  // Register copy at reset values, live decoder state and the state the stimulus plans on
  cfg_t       cfg_model = '{rle_enable: 1'b1, pixel_bits_code: 2'd3, plane_count: 3'd1,
                            bytes_per_plane_line: 16'd1, image_width: 17'd1,
                            image_height: 17'd1};
  dec_state_t decoder_st = '0;
  dec_state_t plan_st = '0;

  logic [7:0] byte_stream[$];
  res_t       expected_pixels[$];
  res_t       plan_pixels[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  no_idle = 1'b0;

  pcx_rle_scanline_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_byte_o   (pixel_byte_o),
    .plane_index_o  (plane_index_o),
    .line_number_o  (line_number_o),
    .first_column_o (first_column_o),
    .valid_pixels_o (valid_pixels_o),
    .line_end_o     (line_end_o),
    .image_end_o    (image_end_o),
    .run_end_o      (run_end_o),
    .run_error_o    (run_error_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Out-of-range register values fold onto the nearest legal one
  function automatic int unsigned eff_bpl(cfg_t c);
    return (c.bytes_per_plane_line == 0) ? 1 : 32'(c.bytes_per_plane_line);
  endfunction

  function automatic int unsigned eff_planes(cfg_t c);
    if (c.plane_count == 0) return 1;
    if (c.plane_count > 4) return 4;
    return 32'(c.plane_count);
  endfunction

  function automatic int unsigned eff_height(cfg_t c);
    if (c.image_height == 0) return 1;
    if (c.image_height > 65536) return 65536;
    return 32'(c.image_height);
  endfunction

  // Bytes still to come in this line over all planes, current byte included
  function automatic int unsigned line_bytes_left(dec_state_t s, cfg_t c);
    int unsigned bpl;
    int unsigned planes;
    int unsigned in_plane;
    int unsigned later;
    bpl = eff_bpl(c);
    planes = eff_planes(c);
    in_plane = (s.byte_pos < bpl) ? bpl - s.byte_pos : 1;
    later = (s.plane + 1 < planes) ? planes - 1 - s.plane : 0;
    return in_plane + later * bpl;
  endfunction

  // One decoded byte: tag it with its position, then step position, plane and line
  function automatic void emit_pixel_byte(inout dec_state_t s, input cfg_t c,
                                          input logic [7:0] value, input bit last,
                                          inout res_t q[$]);
    int unsigned bpl;
    int unsigned planes;
    int unsigned ppb;
    int unsigned col;
    int unsigned valid;
    bit          plane_done;
    bit          line_done;
    bit          image_done;
    res_t        r;
    bpl = eff_bpl(c);
    planes = eff_planes(c);
    ppb = 8 >> c.pixel_bits_code;
    col = s.byte_pos * ppb;
    valid = 0;
    if (col < c.image_width) begin
      valid = c.image_width - col;
      if (valid > ppb) valid = ppb;
    end
    plane_done = (s.byte_pos + 1 >= bpl);
    line_done = plane_done && (s.plane + 1 >= planes);
    image_done = line_done && (s.line + 1 >= eff_height(c));
    r = '0;
    r.pixel_byte = value;
    r.plane_index = s.plane;
    r.line_number = s.line;
    r.first_column = col[18:0];
    r.valid_pixels = valid[3:0];
    r.line_end = line_done;
    r.image_end = image_done;
    r.run_end = last;
    q.push_back(r);
    if (!plane_done) begin
      s.byte_pos = s.byte_pos + 16'd1;
    end else begin
      s.byte_pos = '0;
      if (!line_done) begin
        s.plane = s.plane + 2'd1;
      end else begin
        s.plane = '0;
        s.line = image_done ? 16'd0 : s.line + 16'd1;
      end
    end
  endfunction

  // Decode one incoming byte, queueing every pixel byte it produces
  function automatic void decode_byte(inout dec_state_t s, input cfg_t c,
                                      input logic [7:0] b, inout res_t q[$]);
    int unsigned count;
    int unsigned i;
    res_t        r;
    if (s.halted) return;
    if (s.await_value) begin
      count = 32'(s.pending_count);
      s.await_value = 1'b0;
      s.pending_count = '0;
      if (count == 0) return;
      // run longer than the rest of the line: single error result, then stuck
      if (count > line_bytes_left(s, c)) begin
        r = '0;
        r.run_end = 1'b1;
        r.run_error = 1'b1;
        q.push_back(r);
        s.halted = 1'b1;
        return;
      end
      for (i = 0; i < count; i++) emit_pixel_byte(s, c, b, i + 1 == count, q);
    end else if (c.rle_enable && (b & MARKER_MASK) == MARKER_MASK) begin
      s.await_value = 1'b1;
      s.pending_count = b[5:0] & COUNT_MASK;
    end else begin
      emit_pixel_byte(s, c, b, 1'b1, q);
    end
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    results_seen++;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("pixel_byte", want.pixel_byte, got.pixel_byte);
    compare_field("plane_index", want.plane_index, got.plane_index);
    compare_field("line_number", want.line_number, got.line_number);
    compare_field("first_column", want.first_column, got.first_column);
    compare_field("valid_pixels", want.valid_pixels, got.valid_pixels);
    compare_field("line_end", want.line_end, got.line_end);
    compare_field("image_end", want.image_end, got.image_end);
    compare_field("run_end", want.run_end, got.run_end);
    compare_field("run_error", want.run_error, got.run_error);
  endtask

  // Input side: predict on each transfer, then offer the next byte or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(decoder_st, cfg_model, data_byte_i, expected_pixels);
        void'(byte_stream.pop_front());
      end
      if (byte_stream.size() != 0 && (no_idle || $urandom_range(99) >= 26)) begin
        push <= 1'b1;
        data_byte_i <= byte_stream[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Output side: check each transfer; one long hold-off fills the block up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_result({pixel_byte_o, plane_index_o, line_number_o, first_column_o,
                      valid_pixels_o, line_end_o, image_end_o, run_end_o, run_error_o});
      end
      if (!hold_done && results_seen > 60 && byte_stream.size() > 8) begin
        hold_done <= 1'b1;
        hold_left <= 300;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || $urandom_range(99) >= 26;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_RLE_ENABLE: cfg_model.rle_enable = value[0];
      REG_PIXEL_BITS: cfg_model.pixel_bits_code = value[1:0];
      REG_PLANE_CNT:  cfg_model.plane_count = value[2:0];
      REG_BPL:        cfg_model.bytes_per_plane_line = value[15:0];
      REG_WIDTH:      cfg_model.image_width = value[16:0];
      REG_HEIGHT:     cfg_model.image_height = value[16:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input int unsigned rle, input int unsigned pbc,
                            input int unsigned planes, input int unsigned bpl,
                            input int unsigned width, input int unsigned height);
    write_reg(REG_RLE_ENABLE, CFG_DATA_W'(rle));
    write_reg(REG_PIXEL_BITS, CFG_DATA_W'(pbc));
    write_reg(REG_PLANE_CNT, CFG_DATA_W'(planes));
    write_reg(REG_BPL, CFG_DATA_W'(bpl));
    write_reg(REG_WIDTH, CFG_DATA_W'(width));
    write_reg(REG_HEIGHT, CFG_DATA_W'(height));
    @(negedge clk_i);
  endtask

  // Queue a byte and track where it leaves the decoder, so runs can be sized
  task automatic offer(input logic [7:0] b);
    byte_stream.push_back(b);
    decode_byte(plan_st, cfg_model, b, plan_pixels);
    plan_pixels.delete();
  endtask

  // Mostly marker/value pairs that fit the line, the rest literals
  task automatic offer_random(input int n);
    int          sent;
    int unsigned left;
    int unsigned cnt;
    logic [7:0]  b;
    sent = 0;
    while (sent < n) begin
      if (cfg_model.rle_enable && $urandom_range(99) < 45) begin
        left = line_bytes_left(plan_st, cfg_model);
        if (left > 63) left = 63;
        cnt = ($urandom_range(9) == 0) ? 0 : $urandom_range(left, 1);
        offer({2'b11, cnt[5:0]});
        offer(8'($urandom));
        sent += 2;
      end else begin
        b = 8'($urandom);
        if (cfg_model.rle_enable && b[7:6] == 2'b11) b[$urandom_range(7, 6)] = 1'b0;
        offer(b);
        sent++;
      end
    end
  endtask

  // Idle point: every byte taken, every result seen, pipeline settled
  task automatic drain_all();
    while (byte_stream.size() != 0 || expected_pixels.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    plan_st = decoder_st;
  endtask

  initial begin
    int          p;
    int unsigned bpl_r;
    int unsigned width_r;
    int unsigned height_r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // literals of every top-bit pattern, runs, a zero-count run, a marker-like value
    set_config(1, 3, 3, 4, 10, 2);
    offer(8'h00); offer(8'h3F); offer(8'h7F); offer(8'hBF);
    offer(8'hC3); offer(8'hFF); offer(8'hC0); offer(8'h55);
    offer(8'hC1); offer(8'hC0); offer(8'hC4); offer(8'hAA);
    offer(8'h01); offer(8'hC2);
    drain_all();

    // RLE off with a run value still owed: that byte still expands, then raw
    set_config(0, 0, 2, 3, 20, 1);
    offer(8'hE7); offer(8'hFF); offer(8'hC0); offer(8'h80); offer(8'h01);
    drain_all();

    // zero width, zero planes, zero bytes per line, zero height
    set_config(1, 1, 0, 0, 0, 0);
    offer(8'hC1); offer(8'h12); offer(8'h34);
    drain_all();

    // widest line and image, a full 63-byte run
    set_config(1, 2, 7, 65535, 17'h1FFFF, 65536);
    offer(8'hFF); offer(8'h00); offer(8'h80);
    drain_all();

    // random settings, one phase without any idling
    for (p = 0; p < 8; p++) begin
      bpl_r = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(6, 1);
      width_r = (bpl_r > 16) ? $urandom_range(131071) : $urandom_range(8 * bpl_r + 8);
      height_r = ($urandom_range(9) == 0) ? 17'h1FFFF : $urandom_range(3);
      set_config($urandom_range(4) != 0, $urandom_range(3), $urandom_range(7), bpl_r,
                 width_r, height_r);
      no_idle = (p == 3);
      offer_random(38);
      drain_all();
      no_idle = 1'b0;
    end

    // run past the line end: one error, then everything is dropped
    set_config(1, 3, 1, 2, 16, 2);
    offer(8'h11); offer(8'hFF); offer(8'h5A);
    offer(8'h22); offer(8'hC1); offer(8'h33);
    drain_all();

    if (mismatches == 0) begin
      $display("pcx_rle_scanline_decoder_test: done, clean");
    end else begin
      $display("pcx_rle_scanline_decoder_test: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("pcx_rle_scanline_decoder_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pcx_rle_pkg.sv
rtl/pcx_rle_front.sv
rtl/pcx_rle_cmdq.sv
rtl/pcx_rle_back.sv
rtl/pcx_rle_scanline_decoder.sv
rtl/pcx_rle_checker.sv
dv/pcx_rle_scanline_decoder_test.sv
